// ----- rtl/cd_pkg.sv -----
// shared types and constants for the circular deque
`timescale 1ns / 1ps
`default_nettype none

package cd_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned MODE_W   = 2;

  // request operation codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DENIED = 2'd3;

  // restrict mode bits
  localparam int unsigned MODE_NO_PUSH_FRONT = 0;
  localparam int unsigned MODE_NO_POP_BACK   = 1;

  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_SHIFT_UP   = 3'd1,
    OP_SHIFT_DOWN = 3'd2,
    OP_PUT_BACK   = 3'd3,
    OP_DROP_BACK  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  word;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/cd_cell.sv -----
// one storage cell of the deque chain
`timescale 1ns / 1ps
`default_nettype none

module cd_cell (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire cd_pkg::cell_ctrl_t              ctrl,
  input  wire logic                            left_valid,
  input  wire logic signed [cd_pkg::DATA_W-1:0] left_data,
  input  wire logic                            right_valid,
  input  wire logic signed [cd_pkg::DATA_W-1:0] right_data,
  output logic                                 valid,
  output logic signed [cd_pkg::DATA_W-1:0]     data,
  output logic                                 tail
);

  // last occupied cell of the chain
  assign tail = valid & ~right_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.op)
        cd_pkg::OP_SHIFT_UP: begin
          valid <= left_valid;
        end
        cd_pkg::OP_SHIFT_DOWN: begin
          valid <= right_valid;
        end
        cd_pkg::OP_PUT_BACK: begin
          if (!valid && left_valid) begin
            valid <= 1'b1;
          end
        end
        cd_pkg::OP_DROP_BACK: begin
          if (valid && !right_valid) begin
            valid <= 1'b0;
          end
        end
        default: begin
          valid <= valid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      cd_pkg::OP_SHIFT_UP: begin
        data <= left_data;
      end
      cd_pkg::OP_SHIFT_DOWN: begin
        data <= right_data;
      end
      cd_pkg::OP_PUT_BACK: begin
        if (!valid && left_valid) begin
          data <= ctrl.word;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/circular_deque_top.sv -----
// top level of the circular deque: request decode, cell chain, result register
//
// double-ended queue of DEPTH signed 32-bit words
// - request channel (in_valid / in_ready): cmd picks push front, push back,
//   pop front or pop back; push_value is the word stored by a push
// - result channel (out_valid / out_ready): one result per request with
//   pop_value (the removed word, zero unless a pop succeeds), status
//   (ok, full, empty, not allowed) and occupancy after the request
// - config channel (cfg_valid / cfg_ready): restrict_mode, bit 0 forbids
//   push front, bit 1 forbids pop back; write only while the block is idle
// storage is a row of cells: the front word always sits in cell 0 and every
// cell shifts with its neighbours, so each request touches the whole row in
// one cycle
// latency: the result appears one cycle after the request is taken
// throughput: one request per cycle while results are drained
// when the receiver stalls, the result register holds and in_ready falls
// until the pending result is taken
// reset (synchronous, active high): deque empty, restrict_mode cleared,
// no result pending
`timescale 1ns / 1ps
`default_nettype none

module circular_deque_top #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // request channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [cd_pkg::CMD_W-1:0]             cmd,
  input  wire logic signed [cd_pkg::DATA_W-1:0]     push_value,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [cd_pkg::DATA_W-1:0]          pop_value,
  output logic [cd_pkg::STATUS_W-1:0]               status,
  output logic [cd_pkg::OCC_W-1:0]                  occupancy,
  // config channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [cd_pkg::MODE_W-1:0]            restrict_mode
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [cd_pkg::MODE_W-1:0]          mode;
  logic [CNT_W-1:0]                   count;
  logic [CNT_W-1:0]                   count_next;

  logic                               in_fire;
  logic                               denied;
  logic                               is_push;
  logic                               is_full;
  logic                               is_empty;
  logic [cd_pkg::STATUS_W-1:0]        status_next;
  logic signed [cd_pkg::DATA_W-1:0]   pop_value_next;
  logic signed [cd_pkg::DATA_W-1:0]   back_value;
  logic [31:0]                        count_wide;

  cd_pkg::cell_ctrl_t                 ctrl;

  // cell row wiring
  logic                               cell_valid [DEPTH];
  logic signed [cd_pkg::DATA_W-1:0]   cell_data  [DEPTH];
  logic                               cell_tail  [DEPTH];

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else if (cfg_valid && cfg_ready) begin
      mode <= restrict_mode;
    end
  end

  // take a request whenever the result register is free or being drained
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // request decode: mode check first, then full / empty
  assign denied = ((cmd == cd_pkg::CMD_PUSH_FRONT) && mode[cd_pkg::MODE_NO_PUSH_FRONT]) ||
                  ((cmd == cd_pkg::CMD_POP_BACK)   && mode[cd_pkg::MODE_NO_POP_BACK]);
  assign is_push  = (cmd == cd_pkg::CMD_PUSH_FRONT) || (cmd == cd_pkg::CMD_PUSH_BACK);
  assign is_full  = (count == CNT_W'(DEPTH));
  assign is_empty = (count == '0);

  // back word: one-hot tap on the cell flagged as tail
  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | (cell_data[i] & {cd_pkg::DATA_W{cell_tail[i]}});
    end
  end

  always_comb begin
    status_next    = cd_pkg::ST_OK;
    pop_value_next = '0;
    count_next     = count;
    ctrl.op        = cd_pkg::OP_HOLD;
    ctrl.word      = push_value;
    if (denied) begin
      status_next = cd_pkg::ST_DENIED;
    end else if (is_push && is_full) begin
      status_next = cd_pkg::ST_FULL;
    end else if (!is_push && is_empty) begin
      status_next = cd_pkg::ST_EMPTY;
    end else begin
      case (cmd)
        cd_pkg::CMD_PUSH_FRONT: begin
          ctrl.op    = cd_pkg::OP_SHIFT_UP;
          count_next = count + CNT_W'(1);
        end
        cd_pkg::CMD_PUSH_BACK: begin
          ctrl.op    = cd_pkg::OP_PUT_BACK;
          count_next = count + CNT_W'(1);
        end
        cd_pkg::CMD_POP_FRONT: begin
          ctrl.op        = cd_pkg::OP_SHIFT_DOWN;
          pop_value_next = cell_data[0];
          count_next     = count - CNT_W'(1);
        end
        cd_pkg::CMD_POP_BACK: begin
          ctrl.op        = cd_pkg::OP_DROP_BACK;
          pop_value_next = back_value;
          count_next     = count - CNT_W'(1);
        end
        default: begin
          ctrl.op = cd_pkg::OP_HOLD;
        end
      endcase
    end
    // cells only move on a taken request
    if (!in_fire) begin
      ctrl.op = cd_pkg::OP_HOLD;
    end
  end

  // the row of cells: cell 0 is the front, the tail cell is the back
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                             lv;
    logic signed [cd_pkg::DATA_W-1:0] ld;
    logic                             rv;
    logic signed [cd_pkg::DATA_W-1:0] rd;

    if (g == 0) begin : g_first
      // a push at the front feeds the new word into cell 0
      assign lv = 1'b1;
      assign ld = push_value;
    end else begin : g_mid_left
      assign lv = cell_valid[g-1];
      assign ld = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_mid_right
      assign rv = cell_valid[g+1];
      assign rd = cell_data[g+1];
    end

    cd_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .valid       (cell_valid[g]),
      .data        (cell_data[g]),
      .tail        (cell_tail[g])
    );
  end

  // occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_fire) begin
      count <= count_next;
    end
  end

  // occupancy is reported in its 5-bit field
  assign count_wide = 32'(count_next);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pop_value <= pop_value_next;
      status    <= status_next;
      occupancy <= count_wide[cd_pkg::OCC_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cd_checker.sv -----
// port-level checks for the circular deque, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module cd_checker #(
  parameter int unsigned DEPTH = 16
) (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic [cd_pkg::CMD_W-1:0]             cmd,
  input wire logic signed [cd_pkg::DATA_W-1:0]     push_value,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [cd_pkg::DATA_W-1:0]     pop_value,
  input wire logic [cd_pkg::STATUS_W-1:0]          status,
  input wire logic [cd_pkg::OCC_W-1:0]             occupancy,
  input wire logic                                 cfg_valid,
  input wire logic                                 cfg_ready,
  input wire logic [cd_pkg::MODE_W-1:0]            restrict_mode
);

  localparam logic [31:0] DEPTH_WIDE = 32'(DEPTH);

  // a taken request shows its result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("request taken without a result");

  // an empty status only when nothing is held
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == cd_pkg::ST_EMPTY) |-> (occupancy == '0))
    else $error("empty status with nonzero occupancy");

  // a full status only when every cell is held
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == cd_pkg::ST_FULL) |->
      (occupancy == DEPTH_WIDE[cd_pkg::OCC_W-1:0]))
    else $error("full status with occupancy below depth");

  // failed requests return a zero word
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != cd_pkg::ST_OK) |-> (pop_value == '0))
    else $error("failed request returned a nonzero word");

  // no result pending straight after reset
  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind circular_deque_top cd_checker #(.DEPTH(DEPTH)) u_cd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .cmd           (cmd),
  .push_value    (push_value),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .pop_value     (pop_value),
  .status        (status),
  .occupancy     (occupancy),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready),
  .restrict_mode (restrict_mode)
);

`default_nettype wire

// ----- tb/circular_deque_checker.sv -----
// result predictor and checker for the circular deque
`timescale 1ns / 1ps

module circular_deque_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  input  logic                                     in_ready,
  input  logic [cd_pkg::CMD_W-1:0]                 cmd,
  input  logic signed [cd_pkg::DATA_W-1:0]         push_value,
  input  logic                                     out_valid,
  input  logic                                     out_ready,
  input  logic signed [cd_pkg::DATA_W-1:0]         pop_value,
  input  logic [cd_pkg::STATUS_W-1:0]              status,
  input  logic [cd_pkg::OCC_W-1:0]                 occupancy,
  input  logic                                     cfg_valid,
  input  logic                                     cfg_ready,
  input  logic [cd_pkg::MODE_W-1:0]                restrict_mode,
  output int                                       errors,
  output int                                       outstanding
);

  typedef struct packed {
    logic signed [cd_pkg::DATA_W-1:0] word;
    logic [cd_pkg::STATUS_W-1:0]      stat;
    logic [cd_pkg::OCC_W-1:0]         occ;
  } deque_result_t;

  // own copy of the deque state
  logic signed [cd_pkg::DATA_W-1:0] ring [DEPTH];
  int unsigned                      front_idx;
  int unsigned                      back_idx;
  int unsigned                      fill;
  logic [cd_pkg::MODE_W-1:0]        mode_bits;

  deque_result_t                    due_results [$];
  deque_result_t                    due;
  int                               err_count = 0;

  function automatic deque_result_t predict_request(
    input logic [cd_pkg::CMD_W-1:0]          op,
    input logic signed [cd_pkg::DATA_W-1:0]  word
  );
    deque_result_t res;
    logic          denied;
    res.word = '0;
    res.stat = cd_pkg::ST_OK;
    denied = (op == cd_pkg::CMD_PUSH_FRONT && mode_bits[cd_pkg::MODE_NO_PUSH_FRONT]) ||
             (op == cd_pkg::CMD_POP_BACK && mode_bits[cd_pkg::MODE_NO_POP_BACK]);
    if (denied) begin
      res.stat = cd_pkg::ST_DENIED;
    end else if (op == cd_pkg::CMD_PUSH_FRONT || op == cd_pkg::CMD_PUSH_BACK) begin
      if (fill >= DEPTH) begin
        res.stat = cd_pkg::ST_FULL;
      end else begin
        if (op == cd_pkg::CMD_PUSH_FRONT) begin
          front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
          ring[front_idx] = word;
        end else begin
          back_idx = (back_idx == DEPTH - 1) ? 0 : back_idx + 1;
          ring[back_idx] = word;
        end
        fill++;
      end
    end else begin
      if (fill == 0) begin
        res.stat = cd_pkg::ST_EMPTY;
      end else if (op == cd_pkg::CMD_POP_FRONT) begin
        res.word  = ring[front_idx];
        front_idx = (front_idx == DEPTH - 1) ? 0 : front_idx + 1;
        fill--;
      end else begin
        res.word = ring[back_idx];
        back_idx = (back_idx == 0) ? DEPTH - 1 : back_idx - 1;
        fill--;
      end
    end
    res.occ = fill[cd_pkg::OCC_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      front_idx = 0;
      back_idx  = DEPTH - 1;
      fill      = 0;
      mode_bits = '0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_bits = restrict_mode;
      end
      // the result taken now belongs to an earlier request
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d / %0d / %0d",
                   $time, pop_value, status, occupancy);
          err_count++;
        end else begin
          due = due_results.pop_front();
          if (pop_value !== due.word) begin
            $display("%0t: pop_value mismatch, expected %0d, got %0d",
                     $time, due.word, pop_value);
            err_count++;
          end
          if (status !== due.stat) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, due.stat, status);
            err_count++;
          end
          if (occupancy !== due.occ) begin
            $display("%0t: occupancy mismatch, expected %0d, got %0d",
                     $time, due.occ, occupancy);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        due_results.push_back(predict_request(cmd, push_value));
      end
    end
    outstanding <= due_results.size();
    errors      <= err_count;
  end

endmodule

// ----- tb/testbench.sv -----
// top of the circular deque testbench: clock, reset, request and config stimulus, verdict
`timescale 1ns / 1ps

module testbench;
  import cd_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 37;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_LEN   = 100;

  // restrict_mode settings
  localparam logic [MODE_W-1:0] MODE_FULL_DEQUE        = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INPUT_RESTRICTED  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OUTPUT_RESTRICTED = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BOTH_RESTRICTED   = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [CMD_W-1:0]          cmd = CMD_PUSH_BACK;
  logic signed [DATA_W-1:0]  push_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [DATA_W-1:0]  pop_value;
  logic [STATUS_W-1:0]       status;
  logic [OCC_W-1:0]          occupancy;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [MODE_W-1:0]         restrict_mode = MODE_FULL_DEQUE;

  int                        errors;
  int                        outstanding;
  int                        cycle_count = 0;
  bit                        throttle = 1'b1;   // random idling on both sides
  logic [MODE_W-1:0]         current_mode = MODE_FULL_DEQUE;

  // mode for each random phase: every setting, the extremes more than once
  logic [MODE_W-1:0] phase_mode [PHASES] = '{
    MODE_FULL_DEQUE, MODE_OUTPUT_RESTRICTED, MODE_INPUT_RESTRICTED, MODE_BOTH_RESTRICTED,
    MODE_FULL_DEQUE, MODE_INPUT_RESTRICTED, MODE_OUTPUT_RESTRICTED, MODE_BOTH_RESTRICTED,
    MODE_FULL_DEQUE, MODE_FULL_DEQUE
  };

  circular_deque_top #(.DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .push_value    (push_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pop_value     (pop_value),
    .status        (status),
    .occupancy     (occupancy),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .restrict_mode (restrict_mode)
  );

  circular_deque_checker #(.DEPTH(DEPTH)) deque_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .push_value    (push_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pop_value     (pop_value),
    .status        (status),
    .occupancy     (occupancy),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .restrict_mode (restrict_mode),
    .errors        (errors),
    .outstanding   (outstanding)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: stalls at random while throttling, otherwise always ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !throttle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog, well beyond the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one request: optional random gap, then hold valid until taken
  // valid is only lowered inside the gap loop, so it never drops and rises in one step
  task automatic send_request(input logic [CMD_W-1:0] op, input logic signed [DATA_W-1:0] word);
    while (throttle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    push_value <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // sender holds off until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // mode change, only with the block idle
  task automatic write_mode(input logic [MODE_W-1:0] mode);
    drain_results();
    cfg_valid     <= 1'b1;
    restrict_mode <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    current_mode = mode;
    @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // push_pct biases towards filling or draining the store
  function automatic logic [CMD_W-1:0] pick_cmd(input int unsigned push_pct,
                                               input logic [MODE_W-1:0] mode);
    logic [CMD_W-1:0] op;
    if ($urandom_range(99) < push_pct) begin
      op = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end else begin
      op = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    end
    // most forbidden requests move to the allowed end so the store still fills and drains
    if ($urandom_range(99) >= 10) begin
      if (op == CMD_PUSH_FRONT && mode[MODE_NO_PUSH_FRONT]) op = CMD_PUSH_BACK;
      if (op == CMD_POP_BACK && mode[MODE_NO_POP_BACK]) op = CMD_POP_FRONT;
    end
    return op;
  endfunction

  initial begin
    int unsigned push_pct;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pops, extreme words at both ends, wrap of the head below zero
    write_mode(MODE_FULL_DEQUE);
    send_request(CMD_POP_FRONT, 32'sh1234_5678);
    send_request(CMD_POP_BACK, '1);
    send_request(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_request(CMD_PUSH_BACK, 32'sh8000_0000);
    send_request(CMD_PUSH_FRONT, '0);
    send_request(CMD_PUSH_BACK, '1);
    send_request(CMD_PUSH_FRONT, 32'sh5555_5555);
    send_request(CMD_PUSH_BACK, 32'shAAAA_AAAA);
    send_request(CMD_POP_FRONT, '0);
    send_request(CMD_POP_BACK, '0);
    send_request(CMD_POP_BACK, '1);
    send_request(CMD_POP_FRONT, '1);

    // input restricted: front push refused with state untouched
    write_mode(MODE_INPUT_RESTRICTED);
    send_request(CMD_PUSH_FRONT, 32'sh0BAD_F00D);
    send_request(CMD_PUSH_BACK, 32'sh0000_0001);

    // output restricted: back pop refused
    write_mode(MODE_OUTPUT_RESTRICTED);
    send_request(CMD_PUSH_FRONT, 32'shFFFF_FFFE);
    send_request(CMD_POP_BACK, '0);
    send_request(CMD_POP_FRONT, '0);

    // both bits set: both refusals at once, the rest behaves as a fifo
    write_mode(MODE_BOTH_RESTRICTED);
    send_request(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_request(CMD_POP_BACK, '0);
    send_request(CMD_PUSH_BACK, 32'sh8000_0000);
    send_request(CMD_POP_FRONT, '0);

    // random phases, each under its own mode and fill bias
    for (int p = 0; p < PHASES; p++) begin
      write_mode(phase_mode[p]);
      case (p % 3)
        0:       push_pct = 80;   // runs into full
        1:       push_pct = 20;   // runs into empty
        default: push_pct = 50;
      endcase
      // one long stretch with no idling on either side
      throttle <= (p != 3);
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (p == 5 && i == PHASE_LEN / 2) begin
          drain_results();
        end
        send_request(pick_cmd(push_pct, current_mode), random_word());
      end
    end
    throttle <= 1'b1;

    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cd_pkg.sv
rtl/cd_cell.sv
rtl/circular_deque_top.sv
rtl/cd_checker.sv
tb/circular_deque_checker.sv
tb/testbench.sv
